### rtl/ssd_pkg.sv
// Shared types and codes for the servo status packet deframer.
// No dependencies; compile first.
package ssd_pkg;

    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int OUTCOME_W = 2;
    localparam int CFG_IDX_W = 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE    = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_OK       = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_TIMEOUT  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_HEADER   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_CHECKSUM = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COUNT = 1'd1;

    localparam logic [BYTE_W-1:0] HEADER_BYTE     = 8'hFF;
    localparam logic [BYTE_W-1:0] LENGTH_OVERHEAD = 8'd2;
    localparam logic [BYTE_W-1:0] EXPECTED_ID_RST = 8'd1;

    typedef struct packed {
        logic                 last;
        logic [BYTE_W-1:0]    param_byte;
        logic [BYTE_W-1:0]    param_position;
        logic [BYTE_W-1:0]    packet_id;
        logic [OUTCOME_W-1:0] outcome;
        logic [BYTE_W-1:0]    device_errors;
        logic                 id_mismatch;
        logic                 length_mismatch;
    } t_result;

endpackage

### rtl/ssd_if.sv
// Valid/ready channel interfaces of the servo status packet deframer.
// Depends on ssd_pkg.
interface ssd_in_if import ssd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface ssd_out_if import ssd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 last;
    logic [BYTE_W-1:0]    param_byte;
    logic [BYTE_W-1:0]    param_position;
    logic [BYTE_W-1:0]    packet_id;
    logic [OUTCOME_W-1:0] outcome;
    logic [BYTE_W-1:0]    device_errors;
    logic                 id_mismatch;
    logic                 length_mismatch;
    modport source (output valid, output last, output param_byte, output param_position,
                    output packet_id, output outcome, output device_errors,
                    output id_mismatch, output length_mismatch, input ready);
    modport sink   (input valid, input last, input param_byte, input param_position,
                    input packet_id, input outcome, input device_errors,
                    input id_mismatch, input length_mismatch, output ready);
endinterface

interface ssd_cfg_if import ssd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ssd_parse.sv
// Packet parser: phase sequencer, running checksum and held packet fields.
// Depends on ssd_pkg.
module ssd_parse import ssd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [BYTE_W-1:0] i_expected_id,
    input  logic [BYTE_W-1:0] i_expected_count,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HDR1   = 3'd1;
    localparam logic [2:0] PH_HDR2   = 3'd2;
    localparam logic [2:0] PH_ID     = 3'd3;
    localparam logic [2:0] PH_LEN    = 3'd4;
    localparam logic [2:0] PH_STATUS = 3'd5;
    localparam logic [2:0] PH_PARAMS = 3'd6;
    localparam logic [2:0] PH_CHECK  = 3'd7;

    logic [2:0]        r_phase, n_phase;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_id, n_id;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_status, n_status;
    logic [BYTE_W-1:0] r_left, n_left;
    logic [BYTE_W-1:0] r_count, n_count;

    logic [BYTE_W-1:0] sum_plus;
    logic              len_bad;
    t_result           fin;

    assign sum_plus = r_sum + i_rx_byte;
    assign len_bad  = {1'b0, r_len} != ({1'b0, i_expected_count} + {1'b0, LENGTH_OVERHEAD});

    // Outcome item fields except the code.
    always_comb begin
        fin                 = '0;
        fin.last            = 1'b1;
        fin.packet_id       = r_id;
        fin.device_errors   = r_status;
        fin.id_mismatch     = (r_id != i_expected_id);
        fin.length_mismatch = len_bad;
    end

    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_id        = r_id;
        n_len       = r_len;
        n_status    = r_status;
        n_left      = r_left;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res       = fin;
        if (i_operation == OP_START) begin
            n_phase  = PH_HDR1;
            n_sum    = '0;
            n_id     = HEADER_BYTE;
            n_len    = '0;
            n_status = '0;
            n_left   = '0;
            n_count  = '0;
        end else if (i_operation == OP_TIMEOUT) begin
            if (r_phase != PH_IDLE) begin
                o_res_valid   = 1'b1;
                o_res.outcome = OUT_TIMEOUT;
                n_phase       = PH_IDLE;
            end
        end else if (i_operation == OP_BYTE) begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_HDR1, PH_HDR2: begin
                    if (i_rx_byte != HEADER_BYTE) begin
                        o_res_valid   = 1'b1;
                        o_res.outcome = OUT_HEADER;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_phase = r_phase + 3'd1;
                    end
                end
                PH_ID: begin
                    n_id    = i_rx_byte;
                    n_sum   = i_rx_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_sum   = sum_plus;
                    n_left  = (i_rx_byte > LENGTH_OVERHEAD) ? i_rx_byte - LENGTH_OVERHEAD : '0;
                    n_phase = PH_STATUS;
                end
                PH_STATUS: begin
                    n_status = i_rx_byte;
                    n_sum    = sum_plus;
                    n_phase  = (r_left != '0) ? PH_PARAMS : PH_CHECK;
                end
                PH_PARAMS: begin
                    o_res_valid          = 1'b1;
                    o_res                = '0;
                    o_res.param_byte     = i_rx_byte;
                    o_res.param_position = r_count;
                    o_res.packet_id      = r_id;
                    n_sum                = sum_plus;
                    n_count              = r_count + 8'd1;
                    n_left               = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_res_valid   = 1'b1;
                    o_res.outcome = (i_rx_byte == ~r_sum) ? OUT_OK : OUT_CHECKSUM;
                    n_phase       = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_sum    <= '0;
            r_id     <= '0;
            r_len    <= '0;
            r_status <= '0;
            r_left   <= '0;
            r_count  <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_id     <= n_id;
            r_len    <= n_len;
            r_status <= n_status;
            r_left   <= n_left;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/ssd_out_stage.sv
// Result register between the parser and the output channel.
// Depends on ssd_pkg.
module ssd_out_stage import ssd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_can_take,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // The slot frees in the same cycle its transaction completes.
    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### rtl/servo_status_packet_deframer_core.sv
// Servo status packet deframer, top level. Depends on ssd_pkg, ssd_if, ssd_parse and
// ssd_out_stage.
//
// Takes one transaction per clock on i_in: a start (arms the receiver and drops any
// packet in progress), a received byte, or a receive timeout. Each parameter byte of
// the status packet leaves on o_out as it arrives (last = 0); the checksum byte, a bad
// header byte or a timeout produces one outcome item (last = 1) with the status byte
// and the id and length checks against the two configuration registers. Every input
// transaction is handled in the cycle it is accepted and its result, if any, is in the
// output register on the next cycle, so the block sustains one byte per clock. The
// only thing that stops input is a full output register that downstream is not
// taking: i_in.ready follows o_out.ready combinationally through that register.
// Configuration writes on i_cfg are always taken; write them only while idle.
module servo_status_packet_deframer_core import ssd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ssd_in_if.sink    i_in,
    ssd_out_if.source o_out,
    ssd_cfg_if.sink   i_cfg
);

    logic [BYTE_W-1:0] r_expected_id;
    logic [BYTE_W-1:0] r_expected_count;

    logic    in_fire;
    logic    can_take;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id    <= EXPECTED_ID_RST;
            r_expected_count <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_EXPECTED_ID:    r_expected_id    <= i_cfg.data;
                CFG_EXPECTED_COUNT: r_expected_count <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Accept input whenever the result register can take what it produces.
    assign i_in.ready = can_take;
    assign in_fire    = i_in.valid && can_take;

    ssd_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (in_fire),
        .i_operation      (i_in.operation),
        .i_rx_byte        (i_in.rx_byte),
        .i_expected_id    (r_expected_id),
        .i_expected_count (r_expected_count),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    ssd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_fire && res_valid),
        .i_res      (res),
        .i_ready    (o_out.ready),
        .o_valid    (o_out.valid),
        .o_can_take (can_take),
        .o_res      (out_res)
    );

    // Spread the held result over the output channel's fields.
    assign o_out.last            = out_res.last;
    assign o_out.param_byte      = out_res.param_byte;
    assign o_out.param_position  = out_res.param_position;
    assign o_out.packet_id       = out_res.packet_id;
    assign o_out.outcome         = out_res.outcome;
    assign o_out.device_errors   = out_res.device_errors;
    assign o_out.id_mismatch     = out_res.id_mismatch;
    assign o_out.length_mismatch = out_res.length_mismatch;

endmodule

### tb/servo_status_packet_deframer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for servo_status_packet_deframer_core: directed packet script, then
// randomized packets over several register settings, scored by an in-bench parser and typed rows.
// Depends on ssd_pkg, ssd_if and the deframer RTL.
module servo_status_packet_deframer_core_tb;
    import ssd_pkg::*;

    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;  // spare code, block must ignore it
    localparam logic [BYTE_W-1:0] NO_ID       = 8'hFF; // id reported before the id byte
    localparam int                DRAIN_WAIT  = 4;     // result lands in the cycle after its input
    localparam int                SCRIPT_ROWS = 25;
    localparam int                PHASES      = 5;

    typedef enum logic [2:0] {
        RX_IDLE, RX_HDR1, RX_HDR2, RX_ID, RX_LEN, RX_STATUS, RX_PARAMS, RX_CHECK
    } t_rx_phase;

    typedef enum int {CUT_TIMEOUT, CUT_RESTART, CUT_CORRUPT} t_cut;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        bit                typed;   // want holds a hand-written outcome item
        t_result           want;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    ssd_in_if  in_ch ();
    ssd_out_if out_ch ();
    ssd_cfg_if cfg_ch ();

    servo_status_packet_deframer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Parser shadow: register copies and packet state, updated on every
    // accepted transaction of the matching channel.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] want_id    = EXPECTED_ID_RST;
    logic [BYTE_W-1:0] want_count = 8'd0;

    t_rx_phase         rx_phase    = RX_IDLE;
    logic [BYTE_W-1:0] sum_acc     = 8'd0;
    logic [BYTE_W-1:0] pkt_id      = 8'd0;
    logic [BYTE_W-1:0] pkt_len     = 8'd0;
    logic [BYTE_W-1:0] pkt_status  = 8'd0;
    logic [BYTE_W-1:0] params_todo = 8'd0;
    logic [BYTE_W-1:0] param_idx   = 8'd0;

    t_result rx_items_due [$];   // output items still owed by the block, oldest first

    // Handshake with the monitor: a script row may carry its own expected item.
    bit      row_typed = 1'b0;
    t_result row_item  = '0;

    bit quiet = 1'b0;            // set for the final phase: no idling on either side

    int fail_count     = 0;
    int items_sent     = 0;
    int n_param_items  = 0;
    int n_outcomes [4] = '{0, 0, 0, 0};

    function automatic t_result outcome_item(input logic [BYTE_W-1:0]    id,
                                             input logic [OUTCOME_W-1:0] code,
                                             input logic [BYTE_W-1:0]    dev,
                                             input logic                 idm,
                                             input logic                 lenm);
        t_result r;
        r                 = '0;
        r.last            = 1'b1;
        r.packet_id       = id;
        r.outcome         = code;
        r.device_errors   = dev;
        r.id_mismatch     = idm;
        r.length_mismatch = lenm;
        return r;
    endfunction

    // Close the packet: build the outcome item from what is held and go idle.
    // The length check is done one bit wider so that count 254/255 cannot wrap.
    function automatic t_result close_packet(input logic [OUTCOME_W-1:0] code);
        t_result r;
        r = outcome_item(pkt_id, code, pkt_status, pkt_id != want_id,
                         {1'b0, pkt_len} != ({1'b0, want_count} + {1'b0, LENGTH_OVERHEAD}));
        rx_phase = RX_IDLE;
        return r;
    endfunction

    task automatic deframe_step(input  logic [OP_W-1:0]   op,
                                input  logic [BYTE_W-1:0] b,
                                output bit                produced,
                                output t_result           item);
        produced = 1'b0;
        item     = '0;
        case (op)
            OP_START: begin
                // Arm the receiver; drop whatever packet was in progress.
                rx_phase    = RX_HDR1;
                sum_acc     = 8'd0;
                pkt_id      = NO_ID;
                pkt_len     = 8'd0;
                pkt_status  = 8'd0;
                params_todo = 8'd0;
                param_idx   = 8'd0;
            end
            OP_TIMEOUT: begin
                if (rx_phase != RX_IDLE) begin
                    produced = 1'b1;
                    item     = close_packet(OUT_TIMEOUT);
                end
            end
            OP_BYTE: begin
                case (rx_phase)
                    RX_HDR1, RX_HDR2: begin
                        if (b != HEADER_BYTE) begin
                            produced = 1'b1;
                            item     = close_packet(OUT_HEADER);
                        end else begin
                            rx_phase = (rx_phase == RX_HDR1) ? RX_HDR2 : RX_ID;
                        end
                    end
                    RX_ID: begin
                        pkt_id   = b;
                        sum_acc  = b;
                        rx_phase = RX_LEN;
                    end
                    RX_LEN: begin
                        pkt_len     = b;
                        sum_acc     = sum_acc + b;
                        params_todo = (b > LENGTH_OVERHEAD) ? b - LENGTH_OVERHEAD : 8'd0;
                        rx_phase    = RX_STATUS;
                    end
                    RX_STATUS: begin
                        pkt_status = b;
                        sum_acc    = sum_acc + b;
                        rx_phase   = (params_todo != 8'd0) ? RX_PARAMS : RX_CHECK;
                    end
                    RX_PARAMS: begin
                        produced            = 1'b1;
                        item.param_byte     = b;
                        item.param_position = param_idx;
                        item.packet_id      = pkt_id;
                        sum_acc             = sum_acc + b;
                        param_idx           = param_idx + 8'd1;
                        params_todo         = params_todo - 8'd1;
                        if (params_todo == 8'd0) rx_phase = RX_CHECK;
                    end
                    RX_CHECK: begin
                        produced = 1'b1;
                        item     = close_packet((b == ~sum_acc) ? OUT_OK : OUT_CHECKSUM);
                    end
                    default: ;   // idle: stray bytes are dropped
                endcase
            end
            default: ;           // spare operation code: no effect
        endcase
    endtask

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_output();
        t_result got;
        t_result want;
        got.last            = out_ch.last;
        got.param_byte      = out_ch.param_byte;
        got.param_position  = out_ch.param_position;
        got.packet_id       = out_ch.packet_id;
        got.outcome         = out_ch.outcome;
        got.device_errors   = out_ch.device_errors;
        got.id_mismatch     = out_ch.id_mismatch;
        got.length_mismatch = out_ch.length_mismatch;
        if (got.last) n_outcomes[got.outcome]++;
        else n_param_items++;
        if (rx_items_due.size() == 0) begin
            $display("%0t: unexpected output item, expected none, actual %h", $time, got);
            fail_count++;
        end else begin
            want = rx_items_due.pop_front();
            check_field("last", want.last, got.last);
            check_field("param_byte", want.param_byte, got.param_byte);
            check_field("param_position", want.param_position, got.param_position);
            check_field("packet_id", want.packet_id, got.packet_id);
            check_field("outcome", want.outcome, got.outcome);
            check_field("device_errors", want.device_errors, got.device_errors);
            check_field("id_mismatch", want.id_mismatch, got.id_mismatch);
            check_field("length_mismatch", want.length_mismatch, got.length_mismatch);
        end
    endtask

    // Sample every channel at the rising edge; the stimulus only moves at the
    // falling edge, so everything read here is stable. An input taken at this
    // edge cannot have its result on the output yet, so the order is free.
    always @(posedge i_clk) begin
        bit      produced;
        t_result item;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) check_output();
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_EXPECTED_ID:    want_id    = cfg_ch.data;
                    CFG_EXPECTED_COUNT: want_count = cfg_ch.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                deframe_step(in_ch.operation, in_ch.rx_byte, produced, item);
                // A typed row overrides the shadow parser's item, not its state.
                if (row_typed) rx_items_due.push_back(row_item);
                else if (produced) rx_items_due.push_back(item);
            end
        end
    end

    // ------------------------------------------------------------------
    // Clock, watchdog and downstream stalls
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // Hold ready low in random bursts, with long open stretches between.
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Present one input transaction at the falling edge, hold it until taken, and
    // return at the next falling edge. Valid is left high so back-to-back calls
    // stream without a bubble, bar random idle gaps outside the quiet phase.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                             input bit typed, input t_result want);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.operation = op;
        in_ch.rx_byte   = data;
        row_typed       = typed;
        row_item        = want;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
        items_sent++;
    endtask

    // Drop input valid, wait for every owed item, then let the pipe settle.
    task automatic await_idle();
        in_ch.valid = 1'b0;
        row_typed   = 1'b0;
        while (rx_items_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Send one status packet with random content. Many are well formed and match
    // the registers, others carry a random id or length; some are cut short by a
    // timeout or a restart, or carry one corrupted byte (bad header, wrong checksum, odd length).
    task automatic send_packet(input bit full_length);
        logic [BYTE_W-1:0] pkt_bytes [$];
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] sum;
        int                n_body;
        int                cut;
        int                i;
        t_cut              how;
        pkt_bytes = {HEADER_BYTE, HEADER_BYTE};
        pkt_bytes.push_back(($urandom_range(0, 3) != 0) ? want_id : 8'($urandom));
        if (full_length || (want_count <= 8'd8 && $urandom_range(0, 2) != 0))
            len = want_count + LENGTH_OVERHEAD;
        else if ($urandom_range(0, 7) != 0)
            len = 8'($urandom_range(0, 10));
        else
            len = 8'($urandom_range(11, 255));
        pkt_bytes.push_back(len);
        pkt_bytes.push_back(8'($urandom));
        n_body = (len > LENGTH_OVERHEAD) ? int'(len - LENGTH_OVERHEAD) : 0;
        repeat (n_body) pkt_bytes.push_back(8'($urandom));
        sum = 8'd0;
        for (i = 2; i < pkt_bytes.size(); i++) sum = sum + pkt_bytes[i];
        pkt_bytes.push_back(~sum);

        // Long lengths outside the big packet are always cut early, and only by
        // a timeout or a restart, so they cost a handful of transactions.
        cut = -1;
        how = CUT_CORRUPT;
        if (!full_length && len > 8'd10) begin
            cut = $urandom_range(0, 12);
            how = t_cut'($urandom_range(0, 1));
        end else if (!full_length && $urandom_range(0, 3) == 0) begin
            cut = $urandom_range(0, pkt_bytes.size() - 1);
            how = t_cut'($urandom_range(0, 2));
        end

        send_item(OP_START, 8'($urandom), 1'b0, '0);
        for (i = 0; i < pkt_bytes.size(); i++) begin
            if (i != cut) begin
                send_item(OP_BYTE, pkt_bytes[i], 1'b0, '0);
            end else begin
                case (how)
                    CUT_TIMEOUT: begin
                        send_item(OP_TIMEOUT, 8'($urandom), 1'b0, '0);
                        return;
                    end
                    CUT_RESTART: begin
                        send_item(OP_START, 8'($urandom), 1'b0, '0);
                        return;
                    end
                    default: send_item(OP_BYTE, pkt_bytes[i] ^ 8'($urandom_range(1, 255)),
                                       1'b0, '0);
                endcase
            end
        end
    endtask

    // Directed script: ignored inputs while idle, a bad first and a bad second
    // header byte, a minimal packet with short length and status 0xFF, a packet
    // dropped by a start after its first parameter, and a timeout mid-header.
    t_script_row script [SCRIPT_ROWS] = '{
        '{OP_BYTE,    8'h55, 1'b0, '0},   // idle: dropped
        '{OP_TIMEOUT, 8'h00, 1'b0, '0},   // idle: dropped
        '{OP_UNUSED,  8'hA5, 1'b0, '0},   // spare code: dropped
        '{OP_START,   8'h00, 1'b0, '0},
        '{OP_BYTE,    8'h00, 1'b1, outcome_item(NO_ID, OUT_HEADER, 8'h00, 1'b1, 1'b1)},
        '{OP_START,   8'hFF, 1'b0, '0},
        '{OP_BYTE,    8'hFF, 1'b0, '0},
        '{OP_BYTE,    8'hFE, 1'b1, outcome_item(NO_ID, OUT_HEADER, 8'h00, 1'b1, 1'b1)},
        '{OP_START,   8'h00, 1'b0, '0},
        '{OP_BYTE,    8'hFF, 1'b0, '0},
        '{OP_BYTE,    8'hFF, 1'b0, '0},
        '{OP_BYTE,    8'h01, 1'b0, '0},   // id matches reset register
        '{OP_BYTE,    8'h00, 1'b0, '0},   // length 0: no parameters
        '{OP_BYTE,    8'hFF, 1'b0, '0},   // status, all error bits
        '{OP_BYTE,    8'hFF, 1'b1, outcome_item(8'h01, OUT_OK, 8'hFF, 1'b0, 1'b1)},
        '{OP_START,   8'h00, 1'b0, '0},
        '{OP_BYTE,    8'hFF, 1'b0, '0},
        '{OP_BYTE,    8'hFF, 1'b0, '0},
        '{OP_BYTE,    8'hFE, 1'b0, '0},
        '{OP_BYTE,    8'h03, 1'b0, '0},   // one parameter
        '{OP_BYTE,    8'h00, 1'b0, '0},
        '{OP_BYTE,    8'hFF, 1'b0, '0},   // parameter item, scored by the parser
        '{OP_START,   8'h00, 1'b0, '0},   // restart mid-packet: no item
        '{OP_BYTE,    8'hFF, 1'b0, '0},
        '{OP_TIMEOUT, 8'h00, 1'b1, outcome_item(NO_ID, OUT_TIMEOUT, 8'h00, 1'b1, 1'b1)}
    };

    initial begin
        int ph;
        int phase_start;
        int budget;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_START;
        in_ch.rx_byte   = 8'd0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_EXPECTED_ID;
        cfg_ch.data     = 8'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed script with the registers at their reset values.
        for (int r = 0; r < SCRIPT_ROWS; r++)
            send_item(script[r].op, script[r].data, script[r].typed, script[r].want);

        // Random phases, each under its own register setting, written only
        // once the block has drained. Setting one carries the longest packet.
        for (ph = 0; ph < PHASES; ph++) begin
            await_idle();
            quiet = (ph == PHASES - 1);
            case (ph)
                0: begin
                    write_reg(CFG_EXPECTED_ID, 8'd0);
                    write_reg(CFG_EXPECTED_COUNT, 8'd0);
                end
                1: begin
                    write_reg(CFG_EXPECTED_ID, 8'd254);
                    write_reg(CFG_EXPECTED_COUNT, 8'd253);
                end
                default: begin
                    write_reg(CFG_EXPECTED_ID, 8'($urandom_range(0, 254)));
                    write_reg(CFG_EXPECTED_COUNT, 8'($urandom_range(0, 6)));
                end
            endcase
            if (ph == 1) send_packet(1'b1);
            budget      = (ph == 1) ? 10 : 35;
            phase_start = items_sent;
            while (items_sent - phase_start < budget) begin
                // Scatter a little noise between packets: any operation, any byte.
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'b0, '0);
                send_packet(1'b0);
            end
        end

        await_idle();
        $display("Ran %0d input transactions under %0d register settings, the last unstalled.",
                 items_sent, PHASES + 1);
        $display("Scored %0d parameter bytes; outcomes ok %0d, timeout %0d, header %0d, sum %0d.",
                 n_param_items, n_outcomes[OUT_OK], n_outcomes[OUT_TIMEOUT],
                 n_outcomes[OUT_HEADER], n_outcomes[OUT_CHECKSUM]);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
